// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the smoothing core.
// Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, prop)
`define ASSERT_NEVER(lbl, prop)
`endif
`endif

// ===== rtl/core/abse_pkg.sv =====
// Shared types and constants for the adaptive box smoothing core.
// No dependencies.
package abse_pkg;
  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned XW = $clog2(MaxWidth);
  localparam int unsigned YW = $clog2(MaxHeight);
  localparam int unsigned AW = XW + YW;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [1:0] RegMinTotal = 2'd0;
  localparam logic [1:0] RegMinExpo  = 2'd1;
  localparam logic [1:0] RegWidth    = 2'd2;
  localparam logic [1:0] RegHeight   = 2'd3;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StMask = 2'd1;
  localparam logic [1:0] StNpos = 2'd2;
  localparam logic [1:0] StSat  = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;      // write pixel pair
    logic setup;     // latch query center
    logic rd;        // issue read at cursor
    logic acc;       // accumulate read data
    logic ring;      // open next ring
    logic step;      // advance cursor
    logic div_start;
    logic div_step;
  } abse_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic masked;
    logic done_grow;  // threshold met or full coverage
    logic ring_last;  // cursor at last pixel of ring
    logic cur_valid;  // cursor pixel inside image
    logic div_last;
  } abse_sts_t;
endpackage

// ===== rtl/core/abse_datapath.sv =====
// Datapath: pixel memories, box cursor, accumulators, serial divider.
// Depends on abse_pkg.
module abse_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  abse_pkg::abse_cmd_t cmd_i,
  output abse_pkg::abse_sts_t sts_o,
  input  logic [7:0]          x_i,
  input  logic [7:0]          y_i,
  input  logic [31:0]         counts_value_i,
  input  logic [31:0]         exposure_value_i,
  input  logic [31:0]         min_total_i,
  input  logic [31:0]         min_expo_i,
  input  logic [8:0]          width_i,
  input  logic [8:0]          height_i,
  output logic [31:0]         smoothed_value_o,
  output logic [8:0]          box_radius_o,
  output logic [1:0]          result_status_o
);
  import abse_pkg::*;

  logic [31:0] cmem [MaxWidth*MaxHeight];
  logic [31:0] emem [MaxWidth*MaxHeight];
  logic [31:0] crd_q, erd_q;

  logic [9:0] w, h;            // effective dims
  logic signed [10:0] cx_q, cy_q, px_q, py_q;
  logic [8:0] r_q;
  logic signed [47:0] cs_q, es_q;
  logic [AW-1:0] raddr;
  logic signed [10:0] xmax, ymax;
  logic signed [10:0] qx, qy;

  // divider state
  logic [63:0] quo_q, rem_q;
  logic [47:0] div_q;
  logic neg_q, npos_q;
  logic [6:0] cnt_q;
  logic [64:0] trial;

  always_comb begin
    w = (width_i == 9'd0) ? 10'd1 : ((width_i > 9'(MaxWidth)) ? 10'(MaxWidth) : {1'b0, width_i});
    h = (height_i == 9'd0) ? 10'd1 :
        ((height_i > 9'(MaxHeight)) ? 10'(MaxHeight) : {1'b0, height_i});
    xmax = 11'(w) - 11'sd1;
    ymax = 11'(h) - 11'sd1;
    qx = ({3'b0, x_i} > xmax) ? xmax : {3'b0, x_i};
    qy = ({3'b0, y_i} > ymax) ? ymax : {3'b0, y_i};
    raddr = {py_q[YW-1:0], px_q[XW-1:0]};
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmem[{y_i[YW-1:0], x_i[XW-1:0]}] <= counts_value_i;
      emem[{y_i[YW-1:0], x_i[XW-1:0]}] <= exposure_value_i;
    end
    if (cmd_i.rd) begin
      crd_q <= cmem[raddr];
      erd_q <= emem[raddr];
    end
  end

  logic signed [10:0] rs, x0, x1, y0, y1;
  logic full_cov, on_last;
  always_comb begin
    rs = 11'(r_q);
    x0 = cx_q - rs; x1 = cx_q + rs; y0 = cy_q - rs; y1 = cy_q + rs;
    full_cov = (x0 <= 0) && (y0 <= 0) && (x1 >= xmax) && (y1 >= ymax);
    on_last = (px_q == x1) && (py_q == y1);
    sts_o.cur_valid = (px_q >= 0) && (py_q >= 0) && (px_q <= xmax) && (py_q <= ymax);
    sts_o.ring_last = on_last;
    sts_o.masked = $signed(erd_q) <= $signed(min_expo_i);
    sts_o.done_grow = !(cs_q < 48'(signed'(min_total_i))) || full_cov;
    sts_o.div_last = (cnt_q == 7'd63);
  end

  // cursor walks the ring in raster order over its bounding square,
  // skipping interior rows' middle pixels; a new ring starts at its corner
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0; cy_q <= '0; px_q <= '0; py_q <= '0; r_q <= '0;
      cs_q <= '0; es_q <= '0;
    end else begin
      if (cmd_i.setup) begin
        cx_q <= qx; cy_q <= qy; px_q <= qx; py_q <= qy; r_q <= '0;
        cs_q <= '0; es_q <= '0;
      end
      if (cmd_i.acc) begin
        cs_q <= cs_q + 48'(signed'(crd_q));
        es_q <= es_q + 48'(signed'(erd_q));
      end
      if (cmd_i.ring) begin
        r_q <= r_q + 9'd1;
        px_q <= cx_q - rs - 11'sd1;
        py_q <= cy_q - rs - 11'sd1;
      end else if (cmd_i.step) begin
        if (px_q == x1) begin
          px_q <= x0; py_q <= py_q + 11'sd1;
        end else if (py_q != y0 && py_q != y1 && px_q == x0) begin
          px_q <= x1;
        end else begin
          px_q <= px_q + 11'sd1;
        end
      end
    end
  end

  // restoring divider: (|cs| << 16) / es, 64 steps
  always_comb begin
    trial = {rem_q, quo_q[63]} - {17'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q <= '0; rem_q <= '0; div_q <= '0; neg_q <= 1'b0; npos_q <= 1'b0; cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      neg_q  <= cs_q[47];
      npos_q <= (es_q <= 0);
      quo_q  <= {(cs_q[47] ? 48'(-cs_q) : cs_q), 16'b0};
      rem_q  <= '0;
      div_q  <= es_q;
      cnt_q  <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 7'd1;
      if (!trial[64]) begin
        rem_q <= trial[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= {rem_q[62:0], quo_q[63]};
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  always_comb begin
    box_radius_o = r_q;
    if (npos_q) begin
      smoothed_value_o = '0; result_status_o = StNpos;
    end else if (!neg_q && quo_q > 64'h7FFF_FFFF) begin
      smoothed_value_o = 32'h7FFF_FFFF; result_status_o = StSat;
    end else if (neg_q && quo_q > 64'h8000_0000) begin
      smoothed_value_o = 32'h8000_0000; result_status_o = StSat;
    end else begin
      smoothed_value_o = neg_q ? 32'(-quo_q) : quo_q[31:0];
      result_status_o = StOk;
    end
  end
endmodule

// ===== rtl/core/abse_ctrl.sv =====
// Controller state machine for the smoothing core.
// Depends on abse_pkg.
module abse_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                opcode_i,
  output logic                busy_o,
  output logic                res_valid_o,
  output logic                masked_o,
  output abse_pkg::abse_cmd_t cmd_o,
  input  abse_pkg::abse_sts_t sts_i
);
  import abse_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CRD   = 8'b0000_0010,
    S_CCHK  = 8'b0000_0100,
    S_GROW  = 8'b0000_1000,
    S_WALK  = 8'b0001_0000,
    S_WACC  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   mask_q, mask_d;

  always_comb begin
    state_d = state_q;
    mask_d = mask_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (opcode_i == OpLoad) cmd_o.load = 1'b1;
          else begin
            cmd_o.setup = 1'b1;
            state_d = S_CRD;
          end
        end
      end
      S_CRD: begin
        cmd_o.rd = 1'b1;
        state_d = S_CCHK;
      end
      S_CCHK: begin
        if (sts_i.masked) begin
          mask_d = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.acc = 1'b1;
          state_d = S_GROW;
        end
      end
      S_GROW: begin
        if (sts_i.done_grow) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else begin
          cmd_o.ring = 1'b1;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        // cursor on a ring pixel; read it if inside the image
        if (sts_i.cur_valid) begin
          cmd_o.rd = 1'b1;
          state_d = S_WACC;
        end else if (sts_i.ring_last) begin
          state_d = S_GROW;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_WACC: begin
        // read data back: add it, then move on
        cmd_o.acc = 1'b1;
        if (sts_i.ring_last) state_d = S_GROW;
        else begin
          cmd_o.step = 1'b1;
          state_d = S_WALK;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_OUT;
      end
      S_OUT: begin
        mask_d = 1'b0;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; mask_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mask_q <= mask_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign masked_o = mask_q;
endmodule

// ===== rtl/core/adaptive_box_smooth_exposure_unit.sv =====
// Adaptive box smoothing with exposure correction: top level.
// Depends on abse_pkg, abse_ctrl, abse_datapath, assert_macros.svh.
//
// start with opcode 0 stores one counts/exposure pair and gives no
// result; busy stays low, so the next beat may follow at the next edge.
// A query keeps busy high while it grows the box ring by ring, testing
// each ring pixel: one outside the image is skipped, one inside it is
// read then added through the single memory read port; then a 64-step
// restoring divider runs. The result is on the output ports for exactly
// one cycle, the last busy one, with valid_o high; the receiver cannot
// stall it. A masked query skips the ring walk and the divider.
// cfg_ready_o is low while a query runs or a command beat is offered, so
// configuration only changes while nothing is in flight.
`include "assert_macros.svh"
module adaptive_box_smooth_exposure_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [7:0]  x_i,
  input  logic [7:0]  y_i,
  input  logic [31:0] counts_value_i,
  input  logic [31:0] exposure_value_i,
  output logic        valid_o,
  output logic [31:0] smoothed_value_o,
  output logic [8:0]  box_radius_o,
  output logic [1:0]  result_status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import abse_pkg::*;

  logic [31:0] min_total_q, min_expo_q;
  logic [8:0]  width_q, height_q;

  assign cfg_ready_o = !busy && !start;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_total_q <= '0; min_expo_q <= '0;
      width_q <= 9'd256; height_q <= 9'd256;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegMinTotal: min_total_q <= cfg_data_i;
        RegMinExpo:  min_expo_q <= cfg_data_i;
        RegWidth:    width_q <= cfg_data_i[8:0];
        RegHeight:   height_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  abse_cmd_t cmd;
  abse_sts_t sts;
  logic res_valid, masked;
  logic [31:0] dp_val;
  logic [8:0]  dp_rad;
  logic [1:0]  dp_st;

  abse_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .opcode_i, .busy_o(busy),
    .res_valid_o(res_valid), .masked_o(masked), .cmd_o(cmd), .sts_i(sts)
  );

  abse_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .x_i, .y_i,
    .counts_value_i, .exposure_value_i,
    .min_total_i(min_total_q), .min_expo_i(min_expo_q),
    .width_i(width_q), .height_i(height_q),
    .smoothed_value_o(dp_val), .box_radius_o(dp_rad), .result_status_o(dp_st)
  );

  assign valid_o = res_valid;
  assign smoothed_value_o = masked ? 32'd0 : dp_val;
  assign box_radius_o = masked ? 9'd0 : dp_rad;
  assign result_status_o = masked ? StMask : dp_st;

  `ASSERT_NEVER(a_res_idle, valid_o && !busy)
  `ASSERT_IMPL(a_res_one, valid_o |=> !valid_o)
  `ASSERT_NEVER(a_div_ring, cmd.div_step && cmd.ring)
endmodule
